// ===== rtl/core/gpc_pkg.sv =====
// Shared types and register map constants of the GPIO port controller.
`default_nettype none

package gpc_pkg;

    // Item and result field widths (fixed by the bus and event interfaces).
    localparam int DATA_W  = 32;
    localparam int OFF_W   = 9;
    localparam int LINE_W  = 7;
    localparam int MODE_W  = 2;
    localparam int LEVEL_W = 2;

    // Item kinds.
    localparam logic [MODE_W-1:0] MODE_READ  = 2'd0;
    localparam logic [MODE_W-1:0] MODE_WRITE = 2'd1;
    localparam logic [MODE_W-1:0] MODE_EVENT = 2'd2;

    // Line levels; any code above high counts as unknown.
    localparam logic [LEVEL_W-1:0] LEVEL_LOW     = 2'd0;
    localparam logic [LEVEL_W-1:0] LEVEL_HIGH    = 2'd1;
    localparam logic [LEVEL_W-1:0] LEVEL_UNKNOWN = 2'd2;

    // Register map (byte offsets).
    localparam logic [OFF_W-1:0] OFF_PER  = 9'h000;
    localparam logic [OFF_W-1:0] OFF_PDR  = 9'h004;
    localparam logic [OFF_W-1:0] OFF_PSR  = 9'h008;
    localparam logic [OFF_W-1:0] OFF_OER  = 9'h010;
    localparam logic [OFF_W-1:0] OFF_ODR  = 9'h014;
    localparam logic [OFF_W-1:0] OFF_OSR  = 9'h018;
    localparam logic [OFF_W-1:0] OFF_IFER = 9'h020;
    localparam logic [OFF_W-1:0] OFF_IFDR = 9'h024;
    localparam logic [OFF_W-1:0] OFF_IFSR = 9'h028;
    localparam logic [OFF_W-1:0] OFF_SODR = 9'h030;
    localparam logic [OFF_W-1:0] OFF_CODR = 9'h034;
    localparam logic [OFF_W-1:0] OFF_ODSR = 9'h038;
    localparam logic [OFF_W-1:0] OFF_PDSR = 9'h03c;
    localparam logic [OFF_W-1:0] OFF_IER  = 9'h040;
    localparam logic [OFF_W-1:0] OFF_IDR  = 9'h044;
    localparam logic [OFF_W-1:0] OFF_IMR  = 9'h048;
    localparam logic [OFF_W-1:0] OFF_ISR  = 9'h04c;
    localparam logic [OFF_W-1:0] OFF_MDER = 9'h050;
    localparam logic [OFF_W-1:0] OFF_MDDR = 9'h054;
    localparam logic [OFF_W-1:0] OFF_MDSR = 9'h058;
    localparam logic [OFF_W-1:0] OFF_PUDR = 9'h060;
    localparam logic [OFF_W-1:0] OFF_PUER = 9'h064;
    localparam logic [OFF_W-1:0] OFF_PUSR = 9'h068;
    localparam logic [OFF_W-1:0] OFF_ASR  = 9'h070;
    localparam logic [OFF_W-1:0] OFF_BSR  = 9'h074;
    localparam logic [OFF_W-1:0] OFF_ABSR = 9'h078;
    localparam logic [OFF_W-1:0] OFF_OWER = 9'h0a0;
    localparam logic [OFF_W-1:0] OFF_OWDR = 9'h0a4;
    localparam logic [OFF_W-1:0] OFF_OWSR = 9'h0a8;

    typedef struct packed {
        logic [MODE_W-1:0]  mode;
        logic [OFF_W-1:0]   offset;
        logic [DATA_W-1:0]  write_data;
        logic [LINE_W-1:0]  line;
        logic [LEVEL_W-1:0] level;
    } t_item;

    typedef struct packed {
        logic [DATA_W-1:0]  read_data;
        logic               irq;
        logic [DATA_W-1:0]  pin_drive_mask;
        logic [DATA_W-1:0]  pin_drive_level;
        logic               fwd_valid;
        logic [LINE_W-1:0]  fwd_line;
        logic [LEVEL_W-1:0] fwd_level;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/gpc_in_stage.sv =====
// Input register of the GPIO port controller: holds one accepted item.
`default_nettype none

module gpc_in_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_ready,
    input  wire gpc_pkg::t_item i_item,
    input  wire logic          i_take,
    output logic               o_valid,
    output gpc_pkg::t_item     o_item
);
    import gpc_pkg::*;

    logic  r_valid;
    logic  n_valid;
    t_item r_item;
    logic  w_load;

    // The register frees up in the same cycle its item moves on.
    assign o_ready = !r_valid || i_take;
    assign w_load  = i_valid && o_ready;

    always_comb begin
        n_valid = r_valid;
        if (w_load) begin
            n_valid = 1'b1;
        end else if (i_take) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_item <= i_item;
        end
    end

    assign o_valid = r_valid;
    assign o_item  = r_item;

endmodule

`default_nettype wire

// ===== rtl/core/gpc_core.sv =====
// Register file, bus decode and line event routing of the GPIO port controller.
`default_nettype none

module gpc_core #(
    parameter int PIN_COUNT = 32,
    parameter int ADDR_SPAN = 512
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_step,
    input  wire gpc_pkg::t_item i_item,
    output gpc_pkg::t_result   o_result
);
    import gpc_pkg::*;

    localparam int PIN_W = (PIN_COUNT > 1) ? $clog2(PIN_COUNT) : 1;
    localparam logic [OFF_W-1:0]  OFF_MASK = OFF_W'(ADDR_SPAN - 1);
    localparam logic [LINE_W-1:0] BASE_A   = LINE_W'(PIN_COUNT);
    localparam logic [LINE_W-1:0] BASE_B   = LINE_W'(2 * PIN_COUNT);
    localparam logic [LINE_W:0]   LIM_A    = (LINE_W + 1)'(PIN_COUNT);
    localparam logic [LINE_W:0]   LIM_B    = (LINE_W + 1)'(2 * PIN_COUNT);
    localparam logic [LINE_W:0]   LIM_END  = (LINE_W + 1)'(3 * PIN_COUNT);

    typedef logic [PIN_COUNT-1:0] t_pins;

    t_pins r_pio_enable,    n_pio_enable;
    t_pins r_output_enable, n_output_enable;
    t_pins r_filter_enable, n_filter_enable;
    t_pins r_output_data,   n_output_data;
    t_pins r_pin_data,      n_pin_data;
    t_pins r_irq_mask,      n_irq_mask;
    t_pins r_irq_status,    n_irq_status;
    t_pins r_multi_driver,  n_multi_driver;
    t_pins r_pullup_enable, n_pullup_enable;
    t_pins r_periph_b_sel,  n_periph_b_sel;
    t_pins r_out_wr_enable, n_out_wr_enable;
    t_pins r_level_unknown, n_level_unknown;
    logic  r_irq_level,     n_irq_level;

    logic [OFF_W-1:0]   w_off;
    t_pins              w_data;
    logic [LINE_W:0]    w_line_x;
    logic               w_grp0;
    logic               w_grp1;
    logic               w_grp2;
    logic [LINE_W-1:0]  w_pin_line;
    logic [PIN_W-1:0]   w_pin;
    t_pins              w_bit;
    logic               w_bsel;
    logic               w_owned;
    logic               w_drives;
    logic               w_lvl_unknown;
    logic [LEVEL_W-1:0] w_fwd_level;
    t_pins              w_pin_new;
    t_pins              w_status_set;
    t_pins              w_read;
    t_pins              w_mask;
    t_pins              w_level;
    t_result            w_res;

    // Operand decode: the offset wraps at the address span, and the event line
    // splits into its group (pins, peripheral A, peripheral B) and pin index.
    assign w_off         = i_item.offset & OFF_MASK;
    assign w_data        = i_item.write_data[PIN_COUNT-1:0];
    assign w_line_x      = {1'b0, i_item.line};
    assign w_grp0        = w_line_x < LIM_A;
    assign w_grp1        = !w_grp0 && (w_line_x < LIM_B);
    assign w_grp2        = !w_grp0 && !w_grp1 && (w_line_x < LIM_END);
    assign w_pin_line    = w_grp0 ? i_item.line
                         : (w_grp1 ? (i_item.line - BASE_A) : (i_item.line - BASE_B));
    assign w_pin         = w_pin_line[PIN_W-1:0];
    assign w_bit         = t_pins'(1) << w_pin;
    assign w_bsel        = |(r_periph_b_sel & w_bit);
    assign w_owned       = |(r_pio_enable & w_bit);
    assign w_drives      = |(r_output_enable & w_bit);
    assign w_lvl_unknown = i_item.level[1];
    assign w_fwd_level   = w_lvl_unknown ? LEVEL_UNKNOWN : i_item.level;
    assign w_pin_new     = (r_pin_data & ~w_bit)
                         | ((i_item.level == LEVEL_HIGH) ? w_bit : '0);
    assign w_status_set  = r_irq_status | w_bit;

    always_comb begin
        n_pio_enable    = r_pio_enable;
        n_output_enable = r_output_enable;
        n_filter_enable = r_filter_enable;
        n_output_data   = r_output_data;
        n_pin_data      = r_pin_data;
        n_irq_mask      = r_irq_mask;
        n_irq_status    = r_irq_status;
        n_multi_driver  = r_multi_driver;
        n_pullup_enable = r_pullup_enable;
        n_periph_b_sel  = r_periph_b_sel;
        n_out_wr_enable = r_out_wr_enable;
        n_level_unknown = r_level_unknown;
        n_irq_level     = r_irq_level;
        w_read          = '0;
        w_mask          = '0;
        w_level         = '0;
        w_res           = '0;

        unique case (i_item.mode)
            MODE_READ: begin
                unique case (w_off)
                    OFF_PSR:  w_read = r_pio_enable;
                    OFF_OSR:  w_read = r_output_enable;
                    OFF_IFSR: w_read = r_filter_enable;
                    OFF_ODSR: w_read = r_output_data;
                    OFF_PDSR: w_read = (r_pin_data & ~r_level_unknown)
                                     | (r_pullup_enable & r_level_unknown);
                    OFF_IMR:  w_read = r_irq_mask;
                    OFF_ISR: begin
                        // Reading the status clears it and drops the interrupt.
                        w_read       = r_irq_status;
                        n_irq_status = '0;
                        n_irq_level  = 1'b0;
                    end
                    OFF_MDSR: w_read = r_multi_driver;
                    OFF_PUSR: w_read = r_pullup_enable;
                    OFF_ABSR: w_read = r_periph_b_sel;
                    OFF_OWSR: w_read = r_out_wr_enable;
                    default:  w_read = '0;
                endcase
            end
            MODE_WRITE: begin
                unique case (w_off)
                    OFF_PER:  n_pio_enable    = r_pio_enable | w_data;
                    OFF_PDR:  n_pio_enable    = r_pio_enable & ~w_data;
                    OFF_OER:  n_output_enable = r_output_enable | w_data;
                    OFF_ODR:  n_output_enable = r_output_enable & ~w_data;
                    OFF_IFER: n_filter_enable = r_filter_enable | w_data;
                    OFF_IFDR: n_filter_enable = r_filter_enable & ~w_data;
                    OFF_SODR: begin
                        n_output_data = r_output_data | w_data;
                        w_mask        = w_data & r_output_enable;
                        w_level       = w_data & r_output_enable;
                    end
                    OFF_CODR: begin
                        n_output_data = r_output_data & ~w_data;
                        w_mask        = w_data & r_output_enable;
                    end
                    OFF_ODSR: begin
                        n_output_data = (r_output_data & ~r_out_wr_enable)
                                      | (w_data & r_out_wr_enable);
                        w_mask        = r_out_wr_enable;
                        w_level       = w_data & r_out_wr_enable;
                    end
                    OFF_IER:  n_irq_mask      = r_irq_mask | w_data;
                    OFF_IDR:  n_irq_mask      = r_irq_mask & ~w_data;
                    OFF_MDER: n_multi_driver  = r_multi_driver | w_data;
                    OFF_MDDR: n_multi_driver  = r_multi_driver & ~w_data;
                    OFF_PUDR: n_pullup_enable = r_pullup_enable & ~w_data;
                    OFF_PUER: n_pullup_enable = r_pullup_enable | w_data;
                    OFF_ASR:  n_periph_b_sel  = r_periph_b_sel & ~w_data;
                    OFF_BSR:  n_periph_b_sel  = r_periph_b_sel | w_data;
                    OFF_OWER: n_out_wr_enable = r_out_wr_enable | w_data;
                    OFF_OWDR: n_out_wr_enable = r_out_wr_enable & ~w_data;
                    default:  ;
                endcase
            end
            MODE_EVENT: begin
                if (w_grp0) begin
                    // Pins driven by this block ignore their own input level.
                    if (!w_drives) begin
                        if (w_owned) begin
                            n_pin_data      = w_pin_new;
                            n_level_unknown = w_lvl_unknown ? (r_level_unknown | w_bit)
                                                            : (r_level_unknown & ~w_bit);
                            if (w_pin_new != r_pin_data) begin
                                n_irq_status = w_status_set;
                                n_irq_level  = |(w_status_set & r_irq_mask);
                            end
                        end else begin
                            w_res.fwd_valid = 1'b1;
                            w_res.fwd_line  = (w_bsel ? BASE_B : BASE_A) + LINE_W'(w_pin);
                            w_res.fwd_level = w_fwd_level;
                        end
                    end
                end else if ((w_grp1 || w_grp2) && !w_owned && (w_grp2 == w_bsel)) begin
                    w_res.fwd_valid = 1'b1;
                    w_res.fwd_line  = LINE_W'(w_pin);
                    w_res.fwd_level = w_fwd_level;
                end
            end
            default: ;
        endcase

        w_res.read_data       = DATA_W'(w_read);
        w_res.pin_drive_mask  = DATA_W'(w_mask);
        w_res.pin_drive_level = DATA_W'(w_level);
        w_res.irq             = n_irq_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pio_enable    <= '1;
            r_output_enable <= '0;
            r_filter_enable <= '0;
            r_output_data   <= '0;
            r_pin_data      <= '0;
            r_irq_mask      <= '0;
            r_irq_status    <= '0;
            r_multi_driver  <= '0;
            r_pullup_enable <= '0;
            r_periph_b_sel  <= '0;
            r_out_wr_enable <= '0;
            r_level_unknown <= '1;
            r_irq_level     <= 1'b0;
        end else if (i_step) begin
            r_pio_enable    <= n_pio_enable;
            r_output_enable <= n_output_enable;
            r_filter_enable <= n_filter_enable;
            r_output_data   <= n_output_data;
            r_pin_data      <= n_pin_data;
            r_irq_mask      <= n_irq_mask;
            r_irq_status    <= n_irq_status;
            r_multi_driver  <= n_multi_driver;
            r_pullup_enable <= n_pullup_enable;
            r_periph_b_sel  <= n_periph_b_sel;
            r_out_wr_enable <= n_out_wr_enable;
            r_level_unknown <= n_level_unknown;
            r_irq_level     <= n_irq_level;
        end
    end

    assign o_result = w_res;

endmodule

`default_nettype wire

// ===== rtl/core/gpc_out_stage.sv =====
// Result register of the GPIO port controller with its valid/ready handshake.
`default_nettype none

module gpc_out_stage (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_load,
    input  wire gpc_pkg::t_result i_result,
    output logic               o_free,
    output logic               o_valid,
    input  wire logic          i_ready,
    output gpc_pkg::t_result   o_result
);
    import gpc_pkg::*;

    logic    r_valid;
    logic    n_valid;
    t_result r_result;

    // Room for a new result when empty or when the held one leaves now.
    assign o_free = !r_valid || i_ready;

    always_comb begin
        n_valid = r_valid;
        if (i_load) begin
            n_valid = 1'b1;
        end else if (i_ready) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

`default_nettype wire

// ===== rtl/core/gpio_port_controller.sv =====
// Top level of the GPIO port controller: input register, register file and result register.
//
// The input channel (i_in_valid / o_in_ready) carries one item per handshake:
// a bus read, a bus write, or a level event on one of the pin, peripheral A
// or peripheral B lines. The output channel (o_out_valid / i_out_ready)
// returns exactly one result item for every accepted item, in order.
// An accepted item waits in the input register until the result register has
// room; then it is applied to the registers and its result is loaded into the
// result register together. Throughput: one item per clock while the receiver
// does not stall, set by the single register-file update path between the
// input and result registers.
// When the receiver stalls, the result register holds its item and the input
// register holds one more; o_in_ready drops only when both are full, and
// the path comes back to full rate as soon as i_out_ready rises.
// A synchronous active-low reset empties both stages, sets PIO ownership and
// the level-unknown flags for every pin, and clears all other registers and
// the interrupt line. Bus writes and line events take effect in item order,
// and o_irq reports the interrupt level after its own item.
`default_nettype none

module gpio_port_controller #(
    parameter int PIN_COUNT = 32,
    parameter int ADDR_SPAN = 512
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [1:0]  i_mode,
    input  wire logic [8:0]  i_offset,
    input  wire logic [31:0] i_write_data,
    input  wire logic [6:0]  i_line,
    input  wire logic [1:0]  i_level,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_read_data,
    output logic             o_irq,
    output logic [31:0]      o_pin_drive_mask,
    output logic [31:0]      o_pin_drive_level,
    output logic             o_fwd_valid,
    output logic [6:0]       o_fwd_line,
    output logic [1:0]       o_fwd_level
);
    import gpc_pkg::*;

    t_item   w_in_item;
    t_item   w_stage_item;
    t_result w_core_result;
    t_result w_out_result;
    logic    w_stage_valid;
    logic    w_out_free;
    logic    w_take;

    assign w_in_item.mode       = i_mode;
    assign w_in_item.offset     = i_offset;
    assign w_in_item.write_data = i_write_data;
    assign w_in_item.line       = i_line;
    assign w_in_item.level      = i_level;

    // An item moves from the input register through the register file into
    // the result register whenever the result register has room.
    assign w_take = w_stage_valid && w_out_free;

    gpc_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_ready (o_in_ready),
        .i_item  (w_in_item),
        .i_take  (w_take),
        .o_valid (w_stage_valid),
        .o_item  (w_stage_item)
    );

    gpc_core #(
        .PIN_COUNT (PIN_COUNT),
        .ADDR_SPAN (ADDR_SPAN)
    ) u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_step   (w_take),
        .i_item   (w_stage_item),
        .o_result (w_core_result)
    );

    gpc_out_stage u_out_stage (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (w_take),
        .i_result (w_core_result),
        .o_free   (w_out_free),
        .o_valid  (o_out_valid),
        .i_ready  (i_out_ready),
        .o_result (w_out_result)
    );

    assign o_read_data       = w_out_result.read_data;
    assign o_irq             = w_out_result.irq;
    assign o_pin_drive_mask  = w_out_result.pin_drive_mask;
    assign o_pin_drive_level = w_out_result.pin_drive_level;
    assign o_fwd_valid       = w_out_result.fwd_valid;
    assign o_fwd_line        = w_out_result.fwd_line;
    assign o_fwd_level       = w_out_result.fwd_level;

    // With both stages full and the receiver stalled, no item may be taken.
    a_no_overrun: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_stage_valid && o_out_valid && !i_out_ready) |-> !o_in_ready)
        else $error("input accepted while both stages are full");

    // An accepted item is held in the input register on the next cycle.
    a_accept_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> w_stage_valid)
        else $error("accepted item lost from the input register");

    // A result only drives levels on pins inside its drive mask.
    a_drive_in_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_pin_drive_level & ~o_pin_drive_mask) == 32'd0))
        else $error("drive level outside drive mask");

    // A forwarded event never carries bus read data or pin drives.
    a_fwd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_fwd_valid) |->
            (o_read_data == 32'd0 && o_pin_drive_mask == 32'd0))
        else $error("forwarded event mixed with bus result");

endmodule

`default_nettype wire

// ===== tb/gpio_port_controller_checker.sv =====
// Result checker of the GPIO port controller: register-level predictor and in-order compare.
module gpio_port_controller_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_ready,
    input  logic [1:0]  i_mode,
    input  logic [8:0]  i_offset,
    input  logic [31:0] i_write_data,
    input  logic [6:0]  i_line,
    input  logic [1:0]  i_level,
    input  logic        i_out_valid,
    input  logic        i_out_ready,
    input  logic [31:0] i_read_data,
    input  logic        i_irq,
    input  logic [31:0] i_pin_drive_mask,
    input  logic [31:0] i_pin_drive_level,
    input  logic        i_fwd_valid,
    input  logic [6:0]  i_fwd_line,
    input  logic [1:0]  i_fwd_level,
    output int          o_mismatches,
    output int          o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import gpc_pkg::*;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the controller registers.
    logic [31:0] pio_en, out_en, filt_en, out_data, pin_lvl, irq_en, irq_flags;
    logic [31:0] multi_drv, pull_en, b_sel, out_wr_en, lvl_unknown;
    logic        irq_line;

    t_result expected_results[$];

    initial begin
        o_mismatches = 0;
        o_pending = 0;
    end

    // Applies one item to the shadow registers and returns the result it causes.
    function automatic t_result apply_item(input t_item it);
        t_result     r;
        logic [31:0] v;
        logic [31:0] prev_lvl;
        int unsigned grp;
        int unsigned pin;
        logic        bsel;
        logic [1:0]  lvl;
        r = '0;
        case (it.mode)
            MODE_READ: begin
                case (it.offset)
                    OFF_PSR:  r.read_data = pio_en;
                    OFF_OSR:  r.read_data = out_en;
                    OFF_IFSR: r.read_data = filt_en;
                    OFF_ODSR: r.read_data = out_data;
                    OFF_PDSR: r.read_data = (pin_lvl & ~lvl_unknown) | (pull_en & lvl_unknown);
                    OFF_IMR:  r.read_data = irq_en;
                    OFF_ISR: begin
                        r.read_data = irq_flags;
                        irq_flags = '0;
                        irq_line = 1'b0;
                    end
                    OFF_MDSR: r.read_data = multi_drv;
                    OFF_PUSR: r.read_data = pull_en;
                    OFF_ABSR: r.read_data = b_sel;
                    OFF_OWSR: r.read_data = out_wr_en;
                    default:  r.read_data = '0;
                endcase
            end
            MODE_WRITE: begin
                v = it.write_data;
                case (it.offset)
                    OFF_PER:  pio_en = pio_en | v;
                    OFF_PDR:  pio_en = pio_en & ~v;
                    OFF_OER:  out_en = out_en | v;
                    OFF_ODR:  out_en = out_en & ~v;
                    OFF_IFER: filt_en = filt_en | v;
                    OFF_IFDR: filt_en = filt_en & ~v;
                    OFF_SODR: begin
                        out_data = out_data | v;
                        r.pin_drive_mask = v & out_en;
                        r.pin_drive_level = v & out_en;
                    end
                    OFF_CODR: begin
                        out_data = out_data & ~v;
                        r.pin_drive_mask = v & out_en;
                    end
                    OFF_ODSR: begin
                        out_data = (out_data & ~out_wr_en) | (v & out_wr_en);
                        r.pin_drive_mask = out_wr_en;
                        r.pin_drive_level = v & out_wr_en;
                    end
                    OFF_IER:  irq_en = irq_en | v;
                    OFF_IDR:  irq_en = irq_en & ~v;
                    OFF_MDER: multi_drv = multi_drv | v;
                    OFF_MDDR: multi_drv = multi_drv & ~v;
                    OFF_PUDR: pull_en = pull_en & ~v;
                    OFF_PUER: pull_en = pull_en | v;
                    OFF_ASR:  b_sel = b_sel & ~v;
                    OFF_BSR:  b_sel = b_sel | v;
                    OFF_OWER: out_wr_en = out_wr_en | v;
                    OFF_OWDR: out_wr_en = out_wr_en & ~v;
                    default: ;
                endcase
            end
            MODE_EVENT: begin
                grp = it.line / 32;
                pin = it.line % 32;
                bsel = b_sel[pin];
                lvl = (it.level > LEVEL_UNKNOWN) ? LEVEL_UNKNOWN : it.level;
                if (grp == 0) begin
                    if (!out_en[pin]) begin
                        if (pio_en[pin]) begin
                            // The pin belongs to the controller: latch the level and
                            // flag a change. A known level, low or high, clears unknown.
                            prev_lvl = pin_lvl;
                            pin_lvl[pin] = (lvl == LEVEL_HIGH);
                            lvl_unknown[pin] = (lvl == LEVEL_UNKNOWN);
                            if (prev_lvl != pin_lvl) begin
                                irq_flags[pin] = 1'b1;
                                irq_line = |(irq_flags & irq_en);
                            end
                        end else begin
                            r.fwd_valid = 1'b1;
                            r.fwd_line = 7'(32 * (1 + bsel) + pin);
                            r.fwd_level = lvl;
                        end
                    end
                end else if (grp <= 2 && !pio_en[pin] && (grp - 1) == bsel) begin
                    r.fwd_valid = 1'b1;
                    r.fwd_line = 7'(pin);
                    r.fwd_level = lvl;
                end
            end
            default: ;
        endcase
        r.irq = irq_line;
        return r;
    endfunction

    always @(posedge i_clk) begin : watch
        t_item   it;
        t_result got;
        t_result want;
        if (!i_rst_n) begin
            pio_en = '1;
            lvl_unknown = '1;
            out_en = '0;
            filt_en = '0;
            out_data = '0;
            pin_lvl = '0;
            irq_en = '0;
            irq_flags = '0;
            multi_drv = '0;
            pull_en = '0;
            b_sel = '0;
            out_wr_en = '0;
            irq_line = 1'b0;
            expected_results.delete();
        end else begin
            // A result leaves only after its item has passed the input and result registers, so the compare goes first.
            if (i_out_valid && i_out_ready) begin
                got.read_data = i_read_data;
                got.irq = i_irq;
                got.pin_drive_mask = i_pin_drive_mask;
                got.pin_drive_level = i_pin_drive_level;
                got.fwd_valid = i_fwd_valid;
                got.fwd_line = i_fwd_line;
                got.fwd_level = i_fwd_level;
                if (expected_results.size() == 0) begin
                    if (o_mismatches < REPORT_LIMIT)
                        $display("%0t: result with no item pending: rd=%h irq=%b", $realtime,
                                 got.read_data, got.irq);
                    o_mismatches <= o_mismatches + 1;
                end else begin
                    want = expected_results.pop_front();
                    if (got !== want) begin
                        if (o_mismatches < REPORT_LIMIT) begin
                            $display("%0t: mismatch rd %h/%h irq %b/%b mask %h/%h (exp/got)",
                                     $realtime, want.read_data, got.read_data,
                                     want.irq, got.irq, want.pin_drive_mask,
                                     got.pin_drive_mask);
                            $display("  lvl %h/%h fwd %b/%b line %0d/%0d level %0d/%0d",
                                     want.pin_drive_level, got.pin_drive_level,
                                     want.fwd_valid, got.fwd_valid,
                                     want.fwd_line, got.fwd_line, want.fwd_level,
                                     got.fwd_level);
                        end
                        o_mismatches <= o_mismatches + 1;
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                it.mode = i_mode;
                it.offset = i_offset;
                it.write_data = i_write_data;
                it.line = i_line;
                it.level = i_level;
                expected_results.push_back(apply_item(it));
            end
        end
        o_pending <= expected_results.size();
    end

endmodule

// ===== tb/gpio_port_controller_tb.sv =====
// Testbench top of the GPIO port controller: clock, reset, item stimulus and verdict.
module gpio_port_controller_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import gpc_pkg::*;

    localparam int RANDOM_ITEMS = 800;
    // Cycle limit of the watchdog, with a wide margin over a correct run.
    localparam int CYCLE_LIMIT = 200000;
    // Extra wait after the last expected result has been compared.
    localparam int DRAIN_CYCLES = 8;
    // Item kind with no meaning: the block must answer it with a result that carries only the interrupt level.
    localparam logic [MODE_W-1:0] MODE_NONE = 2'd3;
    // An offset with no register behind it.
    localparam logic [OFF_W-1:0] OFF_UNMAPPED = 9'h1fc;
    // Level code above unknown, which the block folds into unknown.
    localparam logic [LEVEL_W-1:0] LEVEL_SPARE = 2'd3;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic [1:0]  mode = '0;
    logic [8:0]  offset = '0;
    logic [31:0] write_data = '0;
    logic [6:0]  line = '0;
    logic [1:0]  level = '0;
    logic        out_ready = 1'b0;
    logic        in_ready;
    logic        out_valid;
    logic [31:0] read_data;
    logic        irq;
    logic [31:0] pin_drive_mask;
    logic [31:0] pin_drive_level;
    logic        fwd_valid;
    logic [6:0]  fwd_line;
    logic [1:0]  fwd_level;
    int          mismatches;
    int          pending;
    int          cycles = 0;
    // While set, neither side inserts gaps or stalls.
    logic        steady = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    gpio_port_controller dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .o_in_ready        (in_ready),
        .i_mode            (mode),
        .i_offset          (offset),
        .i_write_data      (write_data),
        .i_line            (line),
        .i_level           (level),
        .o_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .o_read_data       (read_data),
        .o_irq             (irq),
        .o_pin_drive_mask  (pin_drive_mask),
        .o_pin_drive_level (pin_drive_level),
        .o_fwd_valid       (fwd_valid),
        .o_fwd_line        (fwd_line),
        .o_fwd_level       (fwd_level)
    );

    gpio_port_controller_checker u_checker (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (in_valid),
        .i_in_ready        (in_ready),
        .i_mode            (mode),
        .i_offset          (offset),
        .i_write_data      (write_data),
        .i_line            (line),
        .i_level           (level),
        .i_out_valid       (out_valid),
        .i_out_ready       (out_ready),
        .i_read_data       (read_data),
        .i_irq             (irq),
        .i_pin_drive_mask  (pin_drive_mask),
        .i_pin_drive_level (pin_drive_level),
        .i_fwd_valid       (fwd_valid),
        .i_fwd_line        (fwd_line),
        .i_fwd_level       (fwd_level),
        .o_mismatches      (mismatches),
        .o_pending         (pending)
    );

    // The receiver stalls about one cycle in four, except in the steady stretch.
    // Ready changes on the falling edge, away from the sampling edge.
    always @(negedge i_clk) begin
        out_ready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 25);
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    function automatic t_item mk(input logic [1:0] m, input logic [8:0] off,
                                 input logic [31:0] d, input logic [6:0] ln,
                                 input logic [1:0] lv);
        t_item it;
        it.mode = m;
        it.offset = off;
        it.write_data = d;
        it.line = ln;
        it.level = lv;
        return it;
    endfunction

    // Status offsets; pin data and interrupt status come up more often since
    // they carry the interesting behavior (pull-up merge and read-to-clear).
    function automatic logic [8:0] pick_read_offset();
        case ($urandom_range(0, 12))
            0:       return OFF_PSR;
            1:       return OFF_OSR;
            2:       return OFF_IFSR;
            3:       return OFF_ODSR;
            4, 5:    return OFF_PDSR;
            6:       return OFF_IMR;
            7, 8:    return OFF_ISR;
            9:       return OFF_MDSR;
            10:      return OFF_PUSR;
            11:      return OFF_ABSR;
            default: return OFF_OWSR;
        endcase
    endfunction

    function automatic logic [8:0] pick_write_offset();
        case ($urandom_range(0, 18))
            0:       return OFF_PER;
            1:       return OFF_PDR;
            2:       return OFF_OER;
            3:       return OFF_ODR;
            4:       return OFF_IFER;
            5:       return OFF_IFDR;
            6:       return OFF_SODR;
            7:       return OFF_CODR;
            8:       return OFF_ODSR;
            9:       return OFF_IER;
            10:      return OFF_IDR;
            11:      return OFF_MDER;
            12:      return OFF_MDDR;
            13:      return OFF_PUDR;
            14:      return OFF_PUER;
            15:      return OFF_ASR;
            16:      return OFF_BSR;
            17:      return OFF_OWER;
            default: return OFF_OWDR;
        endcase
    endfunction

    // One random item. Every field starts fully random, so unused fields still
    // toggle every bit; then the kind of item decides which fields matter.
    function automatic t_item random_item();
        t_item it;
        int    pick;
        it = mk(MODE_NONE, 9'($urandom), $urandom, 7'($urandom), 2'($urandom));
        // Write values: full random, a single pin, or a sparse pattern.
        case ($urandom_range(0, 3))
            2:       it.write_data = 32'd1 << $urandom_range(0, 31);
            3:       it.write_data = $urandom & $urandom;
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 30) begin
            it.mode = MODE_READ;
            it.offset = pick_read_offset();
        end else if (pick < 60) begin
            it.mode = MODE_WRITE;
            it.offset = pick_write_offset();
        end else if (pick < 92) begin
            it.mode = MODE_EVENT;
            pick = $urandom_range(0, 99);
            if (pick < 60)
                it.line = 7'($urandom_range(0, 31));
            else if (pick < 95)
                it.line = 7'($urandom_range(32, 95));
            else
                it.line = 7'($urandom_range(96, 127));
            // The spare level code comes up less often than the three real ones.
            it.level = ($urandom_range(0, 9) == 0) ? LEVEL_SPARE : 2'($urandom_range(0, 2));
        end else if (pick < 96) begin
            // Any offset at all, which mostly lands on unmapped space.
            it.mode = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
        end
        return it;
    endfunction

    // Presents one item from a falling edge and holds it until accepted. A gap
    // with valid low comes first about one item in four, except in the steady stretch.
    task automatic drive_item(input t_item it);
        if (!steady && $urandom_range(0, 99) < 25) begin
            repeat ($urandom_range(1, 2)) begin
                @(negedge i_clk);
                in_valid = 1'b0;
            end
        end
        @(negedge i_clk);
        in_valid = 1'b1;
        mode = it.mode;
        offset = it.offset;
        write_data = it.write_data;
        line = it.line;
        level = it.level;
        @(posedge i_clk);
        while (!in_ready)
            @(posedge i_clk);
    endtask

    initial begin : stimulus
        int n;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Reset values: every pin owned, every level unknown with no pull-ups.
        drive_item(mk(MODE_READ, OFF_PSR, '0, '0, LEVEL_LOW));
        drive_item(mk(MODE_READ, OFF_PDSR, '0, '0, LEVEL_LOW));
        // Pull-ups show through wherever the level is still unknown.
        drive_item(mk(MODE_WRITE, OFF_PUER, '1, '0, LEVEL_LOW));
        drive_item(mk(MODE_READ, OFF_PDSR, '0, '0, LEVEL_LOW));
        // A change flags status while masked; unmasking alone leaves the line low,
        // and the next change raises it.
        drive_item(mk(MODE_EVENT, '0, '0, 7'd0, LEVEL_HIGH));
        drive_item(mk(MODE_WRITE, OFF_IER, '1, '0, LEVEL_LOW));
        drive_item(mk(MODE_EVENT, '0, '0, 7'd0, LEVEL_LOW));
        // The spare level code counts as unknown: no latched change on a low pin.
        drive_item(mk(MODE_EVENT, '0, '0, 7'd1, LEVEL_SPARE));
        // Reading status clears it and drops the interrupt.
        drive_item(mk(MODE_READ, OFF_ISR, '0, '0, LEVEL_LOW));
        // Hand pins 4..7 and 31 to the peripherals, 5 and 31 to peripheral B.
        drive_item(mk(MODE_WRITE, OFF_PDR, 32'h8000_00f0, '0, LEVEL_LOW));
        drive_item(mk(MODE_WRITE, OFF_BSR, 32'h8000_0020, '0, LEVEL_LOW));
        drive_item(mk(MODE_EVENT, '0, '0, 7'd4, LEVEL_HIGH));
        drive_item(mk(MODE_EVENT, '0, '0, 7'd31, LEVEL_UNKNOWN));
        // Peripheral events reach the pin only from the selected peripheral.
        drive_item(mk(MODE_EVENT, '0, '0, 7'd36, LEVEL_HIGH));
        drive_item(mk(MODE_EVENT, '0, '0, 7'd68, LEVEL_LOW));
        drive_item(mk(MODE_EVENT, '0, '0, 7'd95, LEVEL_LOW));
        // A line past the three groups is dropped.
        drive_item(mk(MODE_EVENT, '0, '0, 7'd127, LEVEL_HIGH));
        // Output drive through set, clear and the direct write path.
        drive_item(mk(MODE_WRITE, OFF_OER, 32'h0000_ff00, '0, LEVEL_LOW));
        drive_item(mk(MODE_WRITE, OFF_SODR, '1, '0, LEVEL_LOW));
        drive_item(mk(MODE_WRITE, OFF_CODR, 32'h0f0f_0f0f, '0, LEVEL_LOW));
        drive_item(mk(MODE_WRITE, OFF_OWER, 32'h00ff_00ff, '0, LEVEL_LOW));
        // An input event on an output-enabled pin is ignored.
        drive_item(mk(MODE_EVENT, '0, '0, 7'd8, LEVEL_HIGH));
        drive_item(mk(MODE_WRITE, OFF_ODSR, 32'ha5a5_a5a5, '0, LEVEL_LOW));
        // Unmapped space and the meaningless item kind.
        drive_item(mk(MODE_READ, OFF_UNMAPPED, '0, '0, LEVEL_LOW));
        drive_item(mk(MODE_WRITE, OFF_UNMAPPED, '1, '0, LEVEL_LOW));
        drive_item(mk(MODE_NONE, '1, '1, '1, LEVEL_SPARE));

        // Random part, with a stretch in the middle where both sides run flat out.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            steady = (n >= 300 && n < 450);
            drive_item(random_item());
        end

        @(negedge i_clk);
        in_valid = 1'b0;
        steady = 1'b0;
        while (pending != 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/core/gpc_pkg.sv
rtl/core/gpc_in_stage.sv
rtl/core/gpc_core.sv
rtl/core/gpc_out_stage.sv
rtl/core/gpio_port_controller.sv
tb/gpio_port_controller_checker.sv
tb/gpio_port_controller_tb.sv
